### sv/animation_frame_delay_sequencer_top_defines.svh
// shared assertion macros for the frame delay sequencer
`ifndef ANIMATION_FRAME_DELAY_SEQUENCER_TOP_DEFINES_SVH
`define ANIMATION_FRAME_DELAY_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define AFDS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AFDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/afds_pkg.sv
package afds_pkg;

    // item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // configuration register indexes
    localparam logic REG_FRAME_COUNT = 1'b0;
    localparam logic REG_PAUSED      = 1'b1;

    localparam int SLOT_W  = 8;
    localparam int DELAY_W = 16;
    localparam int ACC_W   = 17;
    localparam int COUNT_W = 9;

    localparam logic [DELAY_W-1:0] DEFAULT_DELAY = 16'd100;
    localparam logic [DELAY_W-1:0] CS_LIMIT      = 16'd100;
    localparam logic [DELAY_W-1:0] CS_TO_MS      = 16'd10;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic load_wr;
        logic add;
        logic step;
        logic emit;
        logic emit_empty;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_load;
        logic n_zero;
        logic paused;
        logic hit;
        logic wrap;
    } dp_status_t;

endpackage

### sv/animation_frame_delay_sequencer_top.sv
// Frame delay sequencer. Pulse start while busy is low to hand in one item:
// cmd 0 loads frame_slot's delay from raw_delay (0 -> 100 ms, 1..100 are
// centiseconds, larger values are ms) and restarts at frame 0 with a cleared
// clock; cmd 1, unless paused, advances the ms clock by elapsed_ms and walks
// the frames whose delay it covers. Every item gives exactly one result: done
// is high for one cycle with frame_index and delay_ms, and the receiver cannot
// hold it off, so it must take it in that cycle. Each item is accepted and
// decoded; with frames a table read follows, and a running tick then walks
// the frames, reading one table entry per cycle from the single read port of
// the delay memory. With no frames the result is index 0, delay 100. The next
// item may be started in the cycle that done is shown. frame_count and paused
// are written through wr_en / wr_index / wr_data; the user must do so only
// while busy is low, which the block itself does not enforce. Reading a table
// entry that was never loaded gives an unspecified delay.
module animation_frame_delay_sequencer_top #(
    parameter int MAX_FRAMES = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // item handshake
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  cmd,
    input  logic [afds_pkg::SLOT_W-1:0]           frame_slot,
    input  logic [afds_pkg::DELAY_W-1:0]          raw_delay,
    input  logic [afds_pkg::DELAY_W-1:0]          elapsed_ms,
    // configuration writes
    input  logic                                  wr_en,
    input  logic                                  wr_index,
    input  logic [afds_pkg::COUNT_W-1:0]          wr_data,
    // result
    output logic                                  done,
    output logic [afds_pkg::SLOT_W-1:0]           frame_index,
    output logic [afds_pkg::DELAY_W-1:0]          delay_ms
);

    // the 8-bit slot reaches at most 256 entries
    localparam int DEPTH = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    afds_pkg::dp_cmd_t    dp_cmd;
    afds_pkg::dp_status_t dp_status;

    // sequencing: accept, decode, table read, walk
    afds_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (dp_status),
        .cmd    (dp_cmd),
        .busy   (busy),
        .done   (done)
    );

    // delay table, ms clock, frame pointer and result registers
    afds_dp #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .status      (dp_status),
        .item_cmd    (cmd),
        .frame_slot  (frame_slot),
        .raw_delay   (raw_delay),
        .elapsed_ms  (elapsed_ms),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .frame_index (frame_index),
        .delay_ms    (delay_ms)
    );

endmodule

### sv/afds_ram.sv
module afds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/afds_ctrl.sv
module afds_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  afds_pkg::dp_status_t status,
    output afds_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ISSUE,
        ST_CHECK
    } state_t;

    state_t state_reg, state_next;
    logic   fetch_only_reg, fetch_only_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next      = state_reg;
        fetch_only_next = fetch_only_reg;
        done_next       = 1'b0;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (status.n_zero)
                begin
                    cmd.load_wr    = status.is_load;
                    cmd.emit_empty = 1'b1;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (status.is_load)
                begin
                    cmd.load_wr     = 1'b1;
                    fetch_only_next = 1'b1;
                    state_next      = ST_ISSUE;
                end
                else if (status.paused)
                begin
                    fetch_only_next = 1'b1;
                    state_next      = ST_ISSUE;
                end
                else
                begin
                    cmd.add         = 1'b1;
                    fetch_only_next = 1'b0;
                    state_next      = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (fetch_only_reg || !status.hit)
                begin
                    cmd.emit   = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // step past this frame; a full round ends with a fetch of the start
                    cmd.step = 1'b1;
                    if (status.wrap)
                    begin
                        fetch_only_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fetch_only_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fetch_only_reg <= fetch_only_next;
            done_reg       <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

### sv/afds_dp.sv
module afds_dp #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  afds_pkg::dp_cmd_t                     cmd,
    output afds_pkg::dp_status_t                  status,
    input  logic                                  item_cmd,
    input  logic [afds_pkg::SLOT_W-1:0]           frame_slot,
    input  logic [afds_pkg::DELAY_W-1:0]          raw_delay,
    input  logic [afds_pkg::DELAY_W-1:0]          elapsed_ms,
    input  logic                                  wr_en,
    input  logic                                  wr_index,
    input  logic [afds_pkg::COUNT_W-1:0]          wr_data,
    output logic [afds_pkg::SLOT_W-1:0]           frame_index,
    output logic [afds_pkg::DELAY_W-1:0]          delay_ms
);

    localparam logic [afds_pkg::COUNT_W-1:0] DEPTH_N = afds_pkg::COUNT_W'(DEPTH);

    logic                          cmd_reg;
    logic [afds_pkg::SLOT_W-1:0]   slot_reg;
    logic [afds_pkg::DELAY_W-1:0]  raw_reg;
    logic [afds_pkg::DELAY_W-1:0]  elapsed_reg;
    logic [afds_pkg::SLOT_W-1:0]   cur_reg, cur_next;
    logic [afds_pkg::SLOT_W-1:0]   start_reg;
    logic [afds_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [afds_pkg::COUNT_W-1:0]  count_reg;
    logic                          paused_reg;
    logic [afds_pkg::SLOT_W-1:0]   index_out_reg;
    logic [afds_pkg::DELAY_W-1:0]  delay_out_reg;

    logic [afds_pkg::COUNT_W-1:0]  n_eff;
    logic [afds_pkg::COUNT_W-1:0]  cur_ext;
    logic [afds_pkg::COUNT_W-1:0]  inc_ext;
    logic [afds_pkg::SLOT_W-1:0]   nxt;
    logic [afds_pkg::DELAY_W-1:0]  norm_delay;
    logic [afds_pkg::DELAY_W-1:0]  rdata;
    logic [AW-1:0]                 raddr;
    logic                          ram_we;

    // count clamped to the table depth
    assign n_eff   = (count_reg > DEPTH_N) ? DEPTH_N : count_reg;
    assign cur_ext = {1'b0, cur_reg};
    assign inc_ext = cur_ext + afds_pkg::COUNT_W'(1);
    assign nxt     = (inc_ext >= n_eff) ? '0 : inc_ext[afds_pkg::SLOT_W-1:0];

    // zero means default, small values are centiseconds
    always_comb
    begin
        priority if (raw_reg == '0)
        begin
            norm_delay = afds_pkg::DEFAULT_DELAY;
        end
        else if (raw_reg <= afds_pkg::CS_LIMIT)
        begin
            norm_delay = afds_pkg::DELAY_W'(raw_reg * afds_pkg::CS_TO_MS);
        end
        else
        begin
            norm_delay = raw_reg;
        end
    end

    assign ram_we = cmd.load_wr && ({1'b0, slot_reg} < DEPTH_N);
    assign raddr  = cmd.step ? nxt[AW-1:0] : cur_reg[AW-1:0];

    afds_ram #(
        .WIDTH (afds_pkg::DELAY_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg[AW-1:0]),
        .wdata (norm_delay),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign status.is_load = (cmd_reg == afds_pkg::CMD_LOAD);
    assign status.n_zero  = (n_eff == '0);
    assign status.paused  = paused_reg;
    assign status.hit     = (acc_reg >= {1'b0, rdata});
    assign status.wrap    = (nxt == start_reg);

    always_comb
    begin
        cur_next = cur_reg;
        acc_next = acc_reg;
        priority if (cmd.capture)
        begin
            if (cur_ext >= n_eff)
            begin
                cur_next = '0;
            end
        end
        else if (cmd.load_wr)
        begin
            cur_next = '0;
            acc_next = '0;
        end
        else if (cmd.add)
        begin
            acc_next = acc_reg + {1'b0, elapsed_reg};
        end
        else if (cmd.step)
        begin
            cur_next = nxt;
            acc_next = status.wrap ? '0 : (acc_reg - {1'b0, rdata});
        end
        else
        begin
            cur_next = cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= '0;
            acc_reg    <= '0;
            count_reg  <= '0;
            paused_reg <= 1'b0;
        end
        else
        begin
            cur_reg <= cur_next;
            acc_reg <= acc_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    afds_pkg::REG_FRAME_COUNT: count_reg  <= wr_data;
                    afds_pkg::REG_PAUSED:      paused_reg <= wr_data[0];
                    default:                   count_reg  <= count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg     <= item_cmd;
            slot_reg    <= frame_slot;
            raw_reg     <= raw_delay;
            elapsed_reg <= elapsed_ms;
        end
        if (cmd.add)
        begin
            start_reg <= cur_reg;
        end
        if (cmd.emit_empty)
        begin
            index_out_reg <= '0;
            delay_out_reg <= afds_pkg::DEFAULT_DELAY;
        end
        else if (cmd.emit)
        begin
            index_out_reg <= cur_reg;
            delay_out_reg <= rdata;
        end
    end

    assign frame_index = index_out_reg;
    assign delay_ms    = delay_out_reg;

endmodule

### sv/afds_chk.sv
`include "animation_frame_delay_sequencer_top_defines.svh"

module afds_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // an accepted item keeps the block busy in the next cycle
    `AFDS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

    // no result in the cycle right after an accept
    `AFDS_ASSERT_NEXT(a_accept_no_done, start && !busy, !done, "result too early after accept")

    // a result is shown only once the block is idle again
    `AFDS_ASSERT_SAME(a_done_idle, done, !busy, "result shown while still busy")

    // the result strobe lasts one cycle
    `AFDS_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

endmodule

bind animation_frame_delay_sequencer_top afds_chk u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
